// ===== hw/rtl/kgq_pkg.sv =====
// Shared types and constants for the keyframe gated unit queue.
`default_nettype none

package kgq_pkg;

	// Default sizing
	localparam int MAX_UNITS_DEF     = 16;
	localparam int MAX_UNIT_NALS_DEF = 16;
	localparam int STORE_DEPTH_DEF   = 512;
	localparam int HANDLE_BITS_DEF   = 32;

	// Field widths of the stream words
	localparam int KIND_W    = 2;
	localparam int HANDLE_W  = 32;
	localparam int LIMIT_W   = 5;
	localparam int TDATA_W   = 40;
	localparam int S_TUSER_W = 2;
	localparam int M_TUSER_W = 5;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	// Operation codes carried in the input tuser
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH  = 2'd0,
		KIND_POP   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_RSVD  = 2'd3   // reserved code, changes nothing
	} kgq_kind_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_READ = 1'b1
	} kgq_state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic do_push;   // apply the input word as a push
		logic do_pop;    // read the head entry and advance the head
		logic do_clear;  // empty the committed queue
		logic pop_done;  // store read data is valid this cycle
		logic load_res;  // load the result register
	} kgq_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic queue_empty;
	} kgq_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/kgq_ctrl.sv =====
// Controller state machine: accept handshake, pop read sequencing, result valid.
`default_nettype none

module kgq_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [kgq_pkg::KIND_W-1:0] kind,
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	input  wire kgq_pkg::kgq_stat_t         stat,
	output kgq_pkg::kgq_cmd_t               cmd
);

	kgq_pkg::kgq_state_t state_q, state_d;
	logic                out_valid_q;
	logic                out_free;
	logic                accept;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kgq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == kgq_pkg::ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			kgq_pkg::ST_IDLE: begin
				if (accept) begin
					case (kind)
						kgq_pkg::KIND_PUSH: begin
							cmd.do_push  = 1'b1;
							cmd.load_res = 1'b1;
						end
						kgq_pkg::KIND_POP: begin
							if (stat.queue_empty) begin
								cmd.load_res = 1'b1;
							end else begin
								cmd.do_pop = 1'b1;
								state_d    = kgq_pkg::ST_READ;
							end
						end
						kgq_pkg::KIND_CLEAR: begin
							cmd.do_clear = 1'b1;
							cmd.load_res = 1'b1;
						end
						default: begin
							cmd.load_res = 1'b1;
						end
					endcase
				end
			end
			kgq_pkg::ST_READ: begin
				cmd.pop_done = 1'b1;
				cmd.load_res = 1'b1;
				state_d      = kgq_pkg::ST_IDLE;
			end
			default: begin
				state_d = kgq_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hw/rtl/kgq_datapath.sv =====
// Datapath: descriptor store, ring pointers, unit bookkeeping and result register.
`default_nettype none

module kgq_datapath #(
	parameter int MAX_UNITS     = kgq_pkg::MAX_UNITS_DEF,
	parameter int MAX_UNIT_NALS = kgq_pkg::MAX_UNIT_NALS_DEF,
	parameter int STORE_DEPTH   = kgq_pkg::STORE_DEPTH_DEF,
	parameter int HANDLE_BITS   = kgq_pkg::HANDLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire kgq_pkg::kgq_cmd_t             cmd,
	output kgq_pkg::kgq_stat_t                 stat,
	input  wire logic                          cfg_we,
	input  wire logic [kgq_pkg::LIMIT_W-1:0]   cfg_wdata,
	input  wire logic [kgq_pkg::HANDLE_W-1:0]  in_handle,
	input  wire logic                          in_idr,
	input  wire logic                          in_last,
	output logic                               res_pop_valid,
	output logic [kgq_pkg::HANDLE_W-1:0]       res_handle,
	output logic                               res_is_idr,
	output logic                               res_ends_unit,
	output logic                               res_overflow,
	output logic                               res_flushed,
	output logic                               res_discarded,
	output logic                               res_too_long
);

	localparam int PW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(MAX_UNIT_NALS + 2);
	localparam int UW = $clog2(MAX_UNITS + 1);
	localparam int EW = (UW > kgq_pkg::LIMIT_W) ? UW : kgq_pkg::LIMIT_W;
	localparam int EntW = HANDLE_BITS + 2;

	localparam logic [PW:0]   DEPTH_X  = (PW + 1)'(STORE_DEPTH);
	localparam logic [PW+1:0] DEPTH_XX = (PW + 2)'(STORE_DEPTH);
	localparam logic [CW-1:0] NAL_MAX  = CW'(MAX_UNIT_NALS);
	localparam logic [CW-1:0] NAL_OVER = CW'(MAX_UNIT_NALS + 1);
	localparam logic [EW-1:0] UNIT_MAX = EW'(MAX_UNITS);

	logic [EntW-1:0] mem [STORE_DEPTH];
	logic [EntW-1:0] rd_q;

	logic [PW-1:0]               head_q, tail_q;
	logic [CW-1:0]               pend_cnt_q;
	logic                        pend_idr_q;
	logic [UW-1:0]               unit_cnt_q;
	logic                        wait_q;
	logic [kgq_pkg::LIMIT_W-1:0] limit_q;

	logic [PW:0]      used;
	logic [PW+1:0]    fill;
	logic             store_ok;
	logic [CW-1:0]    cnt_n;
	logic             idr_n;
	logic [EW-1:0]    lim_x, eff_lim;
	logic             too_long, flush, waiting, discard, commit, overflow;
	logic [PW-1:0]    slot;
	logic [EntW-1:0]  wr_entry;

	// Add modulo the store depth; the sum stays below twice the depth
	function automatic logic [PW-1:0] ring_add(input logic [PW-1:0] a, input logic [CW-1:0] b);
		logic [PW:0] sum;
		sum = (PW + 1)'(a) + (PW + 1)'(b);
		if (sum >= DEPTH_X) begin
			sum = sum - DEPTH_X;
		end
		return sum[PW-1:0];
	endfunction

	// Decide what a push does
	always_comb begin
		if (tail_q >= head_q) begin
			used = (PW + 1)'(tail_q) - (PW + 1)'(head_q);
		end else begin
			used = (PW + 1)'(tail_q) + DEPTH_X - (PW + 1)'(head_q);
		end
		fill     = (PW + 2)'(used) + (PW + 2)'(pend_cnt_q) + (PW + 2)'(1);
		store_ok = (pend_cnt_q < NAL_MAX) && (fill < DEPTH_XX);
		cnt_n    = store_ok ? (pend_cnt_q + CW'(1)) : NAL_OVER;
		idr_n    = pend_idr_q | (store_ok & in_idr);

		lim_x = EW'(limit_q);
		if (lim_x == '0) begin
			eff_lim = EW'(1);
		end else if (lim_x > UNIT_MAX) begin
			eff_lim = UNIT_MAX;
		end else begin
			eff_lim = lim_x;
		end

		too_long = cnt_n > NAL_MAX;
		flush    = !too_long && (EW'(unit_cnt_q) >= eff_lim);
		waiting  = wait_q || flush;
		discard  = !too_long && waiting && !idr_n;
		commit   = !too_long && !discard;
		overflow = flush && !idr_n;

		slot     = ring_add(tail_q, pend_cnt_q);
		wr_entry = {in_last, in_idr, HANDLE_BITS'(in_handle)};
	end

	assign stat.queue_empty = (unit_cnt_q == '0);

	// Descriptor store: one write for a push, one registered read for a pop
	always_ff @(posedge clk) begin
		if (cmd.do_push && store_ok) begin
			mem[slot] <= wr_entry;
		end
		if (cmd.do_pop) begin
			rd_q <= mem[head_q];
		end
	end

	// Queue limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= kgq_pkg::LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	// Advance pointers and unit bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			pend_cnt_q <= '0;
			pend_idr_q <= 1'b0;
			unit_cnt_q <= '0;
			wait_q     <= 1'b0;
		end else if (cmd.do_push) begin
			if (in_last) begin
				pend_cnt_q <= '0;
				pend_idr_q <= 1'b0;
				if (flush) begin
					head_q <= tail_q;
				end
				if (commit) begin
					tail_q     <= ring_add(tail_q, cnt_n);
					unit_cnt_q <= (flush ? UW'(0) : unit_cnt_q) + UW'(1);
					wait_q     <= 1'b0;
				end else if (flush) begin
					unit_cnt_q <= '0;
					wait_q     <= 1'b1;
				end
			end else begin
				pend_cnt_q <= cnt_n;
				pend_idr_q <= idr_n;
			end
		end else if (cmd.do_pop) begin
			head_q <= ring_add(head_q, CW'(1));
		end else if (cmd.pop_done) begin
			if (rd_q[EntW-1]) begin
				unit_cnt_q <= unit_cnt_q - UW'(1);
			end
		end else if (cmd.do_clear) begin
			head_q     <= tail_q;
			unit_cnt_q <= '0;
			wait_q     <= 1'b0;
		end
	end

	// Load the result word
	always_ff @(posedge clk) begin
		if (cmd.load_res) begin
			if (cmd.pop_done) begin
				res_pop_valid <= 1'b1;
				res_handle    <= kgq_pkg::HANDLE_W'(rd_q[HANDLE_BITS-1:0]);
				res_is_idr    <= rd_q[HANDLE_BITS];
				res_ends_unit <= rd_q[EntW-1];
				res_overflow  <= 1'b0;
				res_flushed   <= 1'b0;
				res_discarded <= 1'b0;
				res_too_long  <= 1'b0;
			end else begin
				res_pop_valid <= 1'b0;
				res_handle    <= '0;
				res_is_idr    <= 1'b0;
				res_ends_unit <= 1'b0;
				res_overflow  <= cmd.do_push && in_last && overflow;
				res_flushed   <= cmd.do_push && in_last && flush;
				res_discarded <= cmd.do_push && in_last && discard;
				res_too_long  <= cmd.do_push && in_last && too_long;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/keyframe_gated_unit_queue_core.sv =====
// Top level of the keyframe gated access unit queue.
`default_nettype none

// Queue of video access units built from pushed NAL descriptors. Each input
// word is a push, a pop or a clear, chosen by s_tuser, and gives exactly one
// result word. A pop on a non-empty queue goes through ST_READ, since the store
// has a registered read port and the unit count is settled once the end mark
// of the read entry is known. A new word is taken while the result register
// is empty or being drained in the same cycle, so a stalled sink holds the
// input after one result. A unit that ends while the queue holds queue_limit
// units flushes the queue and starts a wait for a keyframe unit; units
// without an IDR descriptor are dropped during the wait. Units longer than
// MAX_UNIT_NALS, or that would fill the store, are dropped and flagged. The
// store has no reset; queue_limit resets to 16; the user must write it through
// cfg_we and cfg_wdata only while idle, which the block does not enforce.
module keyframe_gated_unit_queue_core #(
	parameter int MAX_UNITS     = kgq_pkg::MAX_UNITS_DEF,
	parameter int MAX_UNIT_NALS = kgq_pkg::MAX_UNIT_NALS_DEF,
	parameter int STORE_DEPTH   = kgq_pkg::STORE_DEPTH_DEF,
	parameter int HANDLE_BITS   = kgq_pkg::HANDLE_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [kgq_pkg::LIMIT_W-1:0]     cfg_wdata,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// nal_handle[31:0], nal_is_idr[32], zero fill [39:33]
	input  wire logic [kgq_pkg::TDATA_W-1:0]     s_tdata,
	// kind[1:0]
	input  wire logic [kgq_pkg::S_TUSER_W-1:0]   s_tuser,
	// last_in_unit
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// out_handle[31:0], out_is_idr[32], zero fill [39:33]
	output logic [kgq_pkg::TDATA_W-1:0]          m_tdata,
	// pop_valid[0], overflow_event[1], queue_flushed[2], unit_discarded[3],
	// unit_too_long[4]
	output logic [kgq_pkg::M_TUSER_W-1:0]        m_tuser,
	// out_ends_unit
	output logic                                 m_tlast
);

	kgq_pkg::kgq_cmd_t  cmd;
	kgq_pkg::kgq_stat_t stat;

	logic                          res_pop_valid;
	logic [kgq_pkg::HANDLE_W-1:0]  res_handle;
	logic                          res_is_idr;
	logic                          res_ends_unit;
	logic                          res_overflow;
	logic                          res_flushed;
	logic                          res_discarded;
	logic                          res_too_long;

	kgq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.kind     (s_tuser[kgq_pkg::KIND_W-1:0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	kgq_datapath #(
		.MAX_UNITS     (MAX_UNITS),
		.MAX_UNIT_NALS (MAX_UNIT_NALS),
		.STORE_DEPTH   (STORE_DEPTH),
		.HANDLE_BITS   (HANDLE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_handle     (s_tdata[kgq_pkg::HANDLE_W-1:0]),
		.in_idr        (s_tdata[kgq_pkg::HANDLE_W]),
		.in_last       (s_tlast),
		.res_pop_valid (res_pop_valid),
		.res_handle    (res_handle),
		.res_is_idr    (res_is_idr),
		.res_ends_unit (res_ends_unit),
		.res_overflow  (res_overflow),
		.res_flushed   (res_flushed),
		.res_discarded (res_discarded),
		.res_too_long  (res_too_long)
	);

	// Pack the result word
	assign m_tdata = {{(kgq_pkg::TDATA_W - kgq_pkg::HANDLE_W - 1){1'b0}}, res_is_idr, res_handle};
	assign m_tuser = {res_too_long, res_discarded, res_flushed, res_overflow, res_pop_valid};
	assign m_tlast = res_ends_unit;

	// A started pop completes in the next cycle
	a_pop_completes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.do_pop |=> cmd.pop_done)
		else $error("pop read did not complete");

	// Every result load shows up as a valid word
	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_res |=> m_tvalid)
		else $error("loaded result not presented");

	// No input is taken while a pop read is in flight
	a_no_accept_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_done |-> !s_tready)
		else $error("input accepted during pop read");

	// A popped word always reports a descriptor and no unit flags
	a_pop_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop_done |=> (m_tuser[0] && (m_tuser[4:1] == '0)))
		else $error("pop result flags wrong");

endmodule

`default_nettype wire
